>>> hw/rtl/crsmp_pkg.sv
// Shared types and constants of the cubic Farrow resampler.
package crsmp_pkg;

  localparam int SAMPLE_W = 16;
  localparam int FRAC_W   = 16;
  localparam int POS_W    = 40;
  localparam int STEP_W   = 24;
  localparam int MAXO_W   = 16;
  localparam int CNT_W    = 24;
  localparam int PER_IN   = 16;
  localparam int PER_W    = 5;
  localparam int NUM_W    = 52;
  localparam int WGT_W    = 33;
  localparam int PROD_W   = 49;
  localparam int ACC_W    = 52;
  localparam int CFG_IW   = 2;

  localparam logic [CFG_IW-1:0] CFG_START = 2'd0;
  localparam logic [CFG_IW-1:0] CFG_STEP  = 2'd1;
  localparam logic [CFG_IW-1:0] CFG_MAXO  = 2'd2;

  localparam logic [POS_W-1:0]  START_RST = 40'd65536;
  localparam logic [STEP_W-1:0] STEP_RST  = 24'd65536;
  localparam logic [MAXO_W-1:0] MAXO_RST  = 16'd65535;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] re;
    logic signed [SAMPLE_W-1:0] im;
    logic                       last;
  } smp_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] re;
    logic signed [SAMPLE_W-1:0] im;
    logic [MAXO_W-1:0]          idx;
    logic                       done;
    logic                       run_end;
  } res_t;

  typedef struct packed {
    logic [POS_W-1:0]  start_position;
    logic [STEP_W-1:0] step_ratio;
    logic [MAXO_W-1:0] max_outputs;
  } cfg_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_M2,
    S_M3,
    S_WGT,
    S_MAC,
    S_RND,
    S_FIN
  } seq_state_t;

endpackage

>>> hw/rtl/crsmp_queue.sv
// Two-entry input queue that decouples sample acceptance from interpolation.
module crsmp_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  crsmp_pkg::smp_t    push_data,
  output logic               full,
  input  logic               pop,
  output logic               head_valid,
  output crsmp_pkg::smp_t    head
);

  crsmp_pkg::smp_t mem_r [2];
  logic            wp_r, wp_nxt;
  logic            rp_r, rp_nxt;
  logic [1:0]      cnt_r, cnt_nxt;

  always_comb begin
    wp_nxt  = push ? ~wp_r : wp_r;
    rp_nxt  = pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= push_data;
    end
  end

  assign full       = (cnt_r == 2'd2);
  assign head_valid = (cnt_r != 2'd0);
  assign head       = mem_r[rp_r];

endmodule

>>> hw/rtl/crsmp_seq.sv
// Back-end sequencer: delay line, read position and the shared Farrow datapath.
module crsmp_seq (
  input  logic               clk,
  input  logic               rst_n,
  input  crsmp_pkg::cfg_t    cfg,
  input  logic               head_valid,
  input  crsmp_pkg::smp_t    head,
  output logic               pop,
  output logic               res_valid,
  output crsmp_pkg::res_t    res,
  input  logic               res_ready
);

  crsmp_pkg::seq_state_t state_r, state_nxt;

  logic signed [crsmp_pkg::SAMPLE_W-1:0] dl_re_r [4];
  logic signed [crsmp_pkg::SAMPLE_W-1:0] dl_im_r [4];
  logic signed [crsmp_pkg::SAMPLE_W-1:0] dl_re_nxt [4];
  logic signed [crsmp_pkg::SAMPLE_W-1:0] dl_im_nxt [4];
  logic [crsmp_pkg::POS_W-1:0]   rpos_r, rpos_nxt;
  logic [crsmp_pkg::CNT_W-1:0]   ic_r, ic_nxt;
  logic [crsmp_pkg::CNT_W-1:0]   n_r, n_nxt;
  logic [crsmp_pkg::MAXO_W-1:0]  oc_r, oc_nxt;
  logic                          stop_r, stop_nxt;
  logic [crsmp_pkg::PER_W-1:0]   cnt_r, cnt_nxt;
  logic                          last_r, last_nxt;
  logic                          have_r, have_nxt;
  logic [2:0]                    tap_r, tap_nxt;
  logic [31:0]                   m2_r, m2_nxt;
  logic [47:0]                   m3_r, m3_nxt;
  logic signed [crsmp_pkg::WGT_W-1:0]  w_r [4];
  logic signed [crsmp_pkg::WGT_W-1:0]  w_nxt [4];
  logic signed [crsmp_pkg::PROD_W-1:0] pre_r, pre_nxt, pim_r, pim_nxt;
  logic signed [crsmp_pkg::ACC_W-1:0]  acc_re_r, acc_re_nxt, acc_im_r, acc_im_nxt;
  logic signed [crsmp_pkg::SAMPLE_W-1:0] rre_r, rre_nxt, rim_r, rim_nxt;
  logic [crsmp_pkg::MAXO_W-1:0]  ridx_r, ridx_nxt;

  logic [crsmp_pkg::CNT_W-1:0]   ipos;
  logic                          gate, stop_hit, need_wait, cont;
  logic [15:0]                   mu;
  logic signed [crsmp_pkg::NUM_W-1:0] mm, m2e, m3e, n0, n1, n2, n3;
  logic [crsmp_pkg::POS_W:0]     rsum;
  logic [1:0]                    tap_sel;

  function automatic logic signed [crsmp_pkg::WGT_W-1:0] rnd19(
    input logic signed [crsmp_pkg::NUM_W-1:0] v);
    logic signed [crsmp_pkg::NUM_W-1:0] t;
    t = v + (crsmp_pkg::NUM_W'(1) <<< 18);
    return t[crsmp_pkg::NUM_W-1:19];
  endfunction

  function automatic logic signed [crsmp_pkg::SAMPLE_W-1:0] rnd_sat(
    input logic signed [crsmp_pkg::ACC_W-1:0] v);
    logic signed [crsmp_pkg::ACC_W-1:0] t;
    logic signed [21:0]                 q;
    t = v + (crsmp_pkg::ACC_W'(1) <<< 29);
    q = t[crsmp_pkg::ACC_W-1:30];
    if (q > 22'sd32767) begin
      return 16'sh7fff;
    end else if (q < -22'sd32768) begin
      return 16'sh8000;
    end
    return q[15:0];
  endfunction

  always_comb begin
    ipos      = rpos_r[crsmp_pkg::POS_W-1:crsmp_pkg::FRAC_W];
    gate      = !stop_r && (cnt_r != crsmp_pkg::PER_W'(crsmp_pkg::PER_IN));
    stop_hit  = (ipos == '0) || (oc_r >= cfg.max_outputs);
    need_wait = ({1'b0, ipos} + 25'd2) > {1'b0, n_r};
    cont      = gate && !stop_hit && !need_wait;
    mu        = rpos_r[crsmp_pkg::FRAC_W-1:0];
    mm        = crsmp_pkg::NUM_W'(mu);
    m2e       = crsmp_pkg::NUM_W'(m2_r);
    m3e       = crsmp_pkg::NUM_W'(m3_r);
    n0 = -(mm <<< 32) + (m2e <<< 17) - m3e;
    n1 = (crsmp_pkg::NUM_W'(1) <<< 49) - ((m2e <<< 18) + (m2e <<< 16))
         + ((m3e <<< 1) + m3e);
    n2 = (mm <<< 32) + (m2e <<< 18) - ((m3e <<< 1) + m3e);
    n3 = m3e - (m2e <<< 16);
    rsum    = {1'b0, rpos_r} + (crsmp_pkg::POS_W + 1)'(cfg.step_ratio);
    tap_sel = tap_r[1:0];
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      crsmp_pkg::S_IDLE:  if (head_valid) state_nxt = crsmp_pkg::S_CHECK;
      crsmp_pkg::S_CHECK: if (!have_r || res_ready) begin
        state_nxt = cont ? crsmp_pkg::S_M2 : crsmp_pkg::S_FIN;
      end
      crsmp_pkg::S_M2:    state_nxt = crsmp_pkg::S_M3;
      crsmp_pkg::S_M3:    state_nxt = crsmp_pkg::S_WGT;
      crsmp_pkg::S_WGT:   state_nxt = crsmp_pkg::S_MAC;
      crsmp_pkg::S_MAC:   if (tap_r == 3'd4) state_nxt = crsmp_pkg::S_RND;
      crsmp_pkg::S_RND:   state_nxt = crsmp_pkg::S_CHECK;
      crsmp_pkg::S_FIN:   if (!last_r || res_ready) state_nxt = crsmp_pkg::S_IDLE;
      default: state_nxt = crsmp_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    pop       = 1'b0;
    res_valid = 1'b0;
    res       = '0;
    unique case (state_r)
      crsmp_pkg::S_IDLE:  pop = head_valid;
      crsmp_pkg::S_CHECK: begin
        res_valid   = have_r;
        res.re      = rre_r;
        res.im      = rim_r;
        res.idx     = ridx_r;
        res.run_end = !cont && !last_r;
      end
      crsmp_pkg::S_FIN: begin
        res_valid   = last_r;
        res.idx     = oc_r;
        res.done    = 1'b1;
        res.run_end = 1'b1;
      end
      default: ;
    endcase
  end

  always_comb begin
    dl_re_nxt  = dl_re_r;
    dl_im_nxt  = dl_im_r;
    rpos_nxt   = rpos_r;
    ic_nxt     = ic_r;
    n_nxt      = n_r;
    oc_nxt     = oc_r;
    stop_nxt   = stop_r;
    cnt_nxt    = cnt_r;
    last_nxt   = last_r;
    have_nxt   = have_r;
    tap_nxt    = tap_r;
    m2_nxt     = m2_r;
    m3_nxt     = m3_r;
    w_nxt      = w_r;
    pre_nxt    = pre_r;
    pim_nxt    = pim_r;
    acc_re_nxt = acc_re_r;
    acc_im_nxt = acc_im_r;
    rre_nxt    = rre_r;
    rim_nxt    = rim_r;
    ridx_nxt   = ridx_r;
    unique case (state_r)
      crsmp_pkg::S_IDLE: begin
        if (head_valid) begin
          if (ic_r == '0) begin
            rpos_nxt = cfg.start_position;
          end
          for (int i = 0; i < 3; i++) begin
            dl_re_nxt[i] = dl_re_r[i+1];
            dl_im_nxt[i] = dl_im_r[i+1];
          end
          dl_re_nxt[3] = head.re;
          dl_im_nxt[3] = head.im;
          n_nxt    = ic_r;
          cnt_nxt  = '0;
          have_nxt = 1'b0;
          last_nxt = head.last;
        end
      end
      crsmp_pkg::S_CHECK: begin
        if (!have_r || res_ready) begin
          have_nxt = 1'b0;
          if (gate && stop_hit) begin
            stop_nxt = 1'b1;
          end
        end
      end
      crsmp_pkg::S_M2: m2_nxt = 32'(mu) * 32'(mu);
      crsmp_pkg::S_M3: m3_nxt = 48'(m2_r) * 48'(mu);
      crsmp_pkg::S_WGT: begin
        w_nxt[0]   = rnd19(n0);
        w_nxt[1]   = rnd19(n1);
        w_nxt[2]   = rnd19(n2);
        w_nxt[3]   = rnd19(n3);
        tap_nxt    = '0;
        acc_re_nxt = '0;
        acc_im_nxt = '0;
      end
      crsmp_pkg::S_MAC: begin
        pre_nxt = crsmp_pkg::PROD_W'(w_r[tap_sel]) * crsmp_pkg::PROD_W'(dl_re_r[tap_sel]);
        pim_nxt = crsmp_pkg::PROD_W'(w_r[tap_sel]) * crsmp_pkg::PROD_W'(dl_im_r[tap_sel]);
        if (tap_r != 3'd0) begin
          acc_re_nxt = acc_re_r + crsmp_pkg::ACC_W'(pre_r);
          acc_im_nxt = acc_im_r + crsmp_pkg::ACC_W'(pim_r);
        end
        tap_nxt = tap_r + 3'd1;
      end
      crsmp_pkg::S_RND: begin
        rre_nxt  = rnd_sat(acc_re_r);
        rim_nxt  = rnd_sat(acc_im_r);
        ridx_nxt = oc_r;
        oc_nxt   = oc_r + 16'd1;
        cnt_nxt  = cnt_r + 5'd1;
        have_nxt = 1'b1;
        rpos_nxt = rsum[crsmp_pkg::POS_W] ? '1 : rsum[crsmp_pkg::POS_W-1:0];
      end
      crsmp_pkg::S_FIN: begin
        if (!last_r) begin
          if (ic_r != '1) begin
            ic_nxt = ic_r + 24'd1;
          end
        end else if (res_ready) begin
          for (int i = 0; i < 4; i++) begin
            dl_re_nxt[i] = '0;
            dl_im_nxt[i] = '0;
          end
          rpos_nxt = cfg.start_position;
          ic_nxt   = '0;
          oc_nxt   = '0;
          stop_nxt = 1'b0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= crsmp_pkg::S_IDLE;
      for (int i = 0; i < 4; i++) begin
        dl_re_r[i] <= '0;
        dl_im_r[i] <= '0;
      end
      rpos_r <= crsmp_pkg::START_RST;
      ic_r   <= '0;
      oc_r   <= '0;
      stop_r <= 1'b0;
      cnt_r  <= '0;
      have_r <= 1'b0;
      tap_r  <= '0;
    end else begin
      state_r <= state_nxt;
      dl_re_r <= dl_re_nxt;
      dl_im_r <= dl_im_nxt;
      rpos_r  <= rpos_nxt;
      ic_r    <= ic_nxt;
      oc_r    <= oc_nxt;
      stop_r  <= stop_nxt;
      cnt_r   <= cnt_nxt;
      have_r  <= have_nxt;
      tap_r   <= tap_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r      <= n_nxt;
    last_r   <= last_nxt;
    m2_r     <= m2_nxt;
    m3_r     <= m3_nxt;
    w_r      <= w_nxt;
    pre_r    <= pre_nxt;
    pim_r    <= pim_nxt;
    acc_re_r <= acc_re_nxt;
    acc_im_r <= acc_im_nxt;
    rre_r    <= rre_nxt;
    rim_r    <= rim_nxt;
    ridx_r   <= ridx_nxt;
  end

  a_cnt_limit: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= crsmp_pkg::PER_W'(crsmp_pkg::PER_IN))
    else $error("more outputs than allowed for one item");

  a_no_compute_stopped: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == crsmp_pkg::S_M2) |-> !stop_r)
    else $error("interpolation started after the burst stopped");

  a_res_state: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |-> (state_r == crsmp_pkg::S_CHECK || state_r == crsmp_pkg::S_FIN))
    else $error("result offered outside an emitting state");

  a_pop_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    pop |=> (state_r == crsmp_pkg::S_CHECK))
    else $error("item taken without a check step");

endmodule

>>> hw/rtl/cubic_farrow_resampler_unit.sv
// Top level of the cubic Farrow resampler: registers, queue, sequencer and output stage.
//
// Usage: samples of a burst enter on the in_ channel (valid/ready), the last one
// flagged by in_last_sample. Each sample causes zero to sixteen interpolated
// items on the out_ channel, and the last sample adds a completion item that
// carries the produced count. out_run_end marks the final item caused by a sample.
// A two-entry queue takes samples while the back end works, so the input side
// and the output side stall independently.
// Datapath: every interpolated item passes through the shared multiply and
// accumulate datapath (two weight products, weight forming, four tap products
// and rounding), and each sample also passes through bookkeeping steps.
// The user is to write configuration through cfg_ only while the unit is idle;
// the unit does not enforce this. The first read position takes effect at the
// next burst. Reset restores register defaults and clears the delay line,
// counters and queue. When the receiver stalls, the output register holds its
// item and the sequencer waits at the next result.
module cubic_farrow_resampler_unit (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_wr_en,
  input  logic [crsmp_pkg::CFG_IW-1:0]         cfg_index,
  input  logic [crsmp_pkg::POS_W-1:0]          cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [crsmp_pkg::SAMPLE_W-1:0] in_sample_re,
  input  logic signed [crsmp_pkg::SAMPLE_W-1:0] in_sample_im,
  input  logic                                 in_last_sample,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [crsmp_pkg::SAMPLE_W-1:0] out_re,
  output logic signed [crsmp_pkg::SAMPLE_W-1:0] out_im,
  output logic [crsmp_pkg::MAXO_W-1:0]         out_index,
  output logic                                 out_is_done,
  output logic                                 out_run_end
);

  crsmp_pkg::cfg_t cfg_r, cfg_nxt;
  crsmp_pkg::smp_t push_data, head;
  crsmp_pkg::res_t res, out_r;
  logic            full, pop, head_valid, res_valid, res_ready;
  logic            out_valid_r, out_valid_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr_en) begin
      unique case (cfg_index)
        crsmp_pkg::CFG_START: cfg_nxt.start_position = cfg_data;
        crsmp_pkg::CFG_STEP:  cfg_nxt.step_ratio = cfg_data[crsmp_pkg::STEP_W-1:0];
        crsmp_pkg::CFG_MAXO:  cfg_nxt.max_outputs = cfg_data[crsmp_pkg::MAXO_W-1:0];
        default: ;
      endcase
    end
  end

  assign push_data.re   = in_sample_re;
  assign push_data.im   = in_sample_im;
  assign push_data.last = in_last_sample;
  assign in_ready       = !full;

  crsmp_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (in_valid && !full),
    .push_data  (push_data),
    .full       (full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  crsmp_seq u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .res_valid  (res_valid),
    .res        (res),
    .res_ready  (res_ready)
  );

  assign res_ready = !out_valid_r || out_ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_ready) begin
      out_valid_nxt = res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.start_position <= crsmp_pkg::START_RST;
      cfg_r.step_ratio     <= crsmp_pkg::STEP_RST;
      cfg_r.max_outputs    <= crsmp_pkg::MAXO_RST;
      out_valid_r          <= 1'b0;
    end else begin
      cfg_r       <= cfg_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_r <= res;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_re      = out_r.re;
  assign out_im      = out_r.im;
  assign out_index   = out_r.idx;
  assign out_is_done = out_r.done;
  assign out_run_end = out_r.run_end;

endmodule
